/* design/rgcq_pkg.sv */
// shared constants and codes for the reader gated callback queue
`default_nettype none

package rgcq_pkg;

  localparam int QUEUE_DEPTH_DEF       = 32;
  localparam int READER_COUNT_BITS_DEF = 16;

  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 64;
  localparam int ARG_W    = 64;
  localparam int BUDGET_W = 8;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 6;
  localparam int ENTRY_W  = HANDLE_W + ARG_W;

  localparam logic [CMD_W-1:0] CMD_READ_ENTER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ_EXIT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENQUEUE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POLL       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SYNC       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd3;

endpackage

`default_nettype wire

/* design/rgcq_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module rgcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/rgcq_ctrl.sv */
// command sequencer: reader count, ring pointers, drain loop and result register
`default_nettype none

module rgcq_ctrl #(
  parameter int QUEUE_DEPTH       = rgcq_pkg::QUEUE_DEPTH_DEF,
  parameter int READER_COUNT_BITS = rgcq_pkg::READER_COUNT_BITS_DEF,
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rgcq_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [rgcq_pkg::HANDLE_W-1:0]     in_handler_handle,
  input  wire logic [rgcq_pkg::ARG_W-1:0]        in_handler_argument,
  input  wire logic [rgcq_pkg::BUDGET_W-1:0]     in_drain_budget,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_entry_valid,
  output logic      [rgcq_pkg::HANDLE_W-1:0]     out_handle,
  output logic      [rgcq_pkg::ARG_W-1:0]        out_argument,
  output logic      [rgcq_pkg::STATUS_W-1:0]     out_status,
  output logic      [rgcq_pkg::CNT_W-1:0]        out_drained_count,
  output logic                                   out_readers_held,
  output logic                                   out_last,
  output logic                                   mem_we,
  output logic      [PTR_W-1:0]                  mem_waddr,
  output logic      [rgcq_pkg::ENTRY_W-1:0]      mem_wdata,
  output logic                                   mem_re,
  output logic      [PTR_W-1:0]                  mem_raddr,
  input  wire logic [rgcq_pkg::ENTRY_W-1:0]      mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CAP  = 4'b0100,
    S_SUM  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [READER_COUNT_BITS-1:0]    readers_r, readers_nxt;
  logic [PTR_W-1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [rgcq_pkg::CNT_W-1:0]      limit_r, limit_nxt;
  logic [rgcq_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_entry_r, out_entry_nxt;
  logic [rgcq_pkg::HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [rgcq_pkg::ARG_W-1:0]      out_arg_r, out_arg_nxt;
  logic [rgcq_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [rgcq_pkg::CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                            out_held_r, out_held_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;

  always_comb begin
    logic                          sum_go;
    logic [rgcq_pkg::STATUS_W-1:0] st;
    state_nxt      = state_r;
    readers_nxt    = readers_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    limit_nxt      = limit_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_entry_nxt  = out_entry_r;
    out_handle_nxt = out_handle_r;
    out_arg_nxt    = out_arg_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_held_nxt   = out_held_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    sum_go         = 1'b0;
    st             = rgcq_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          sum_go  = 1'b1;
          cnt_nxt = '0;
          case (in_cmd)
            rgcq_pkg::CMD_READ_ENTER: begin
              if (readers_r != '1) begin
                readers_nxt = readers_r + 1'b1;
              end
            end
            rgcq_pkg::CMD_READ_EXIT: begin
              if (readers_r != '0) begin
                readers_nxt = readers_r - 1'b1;
              end
            end
            rgcq_pkg::CMD_ENQUEUE: begin
              if (in_handler_handle == '0) begin
                st = rgcq_pkg::ST_INVALID;
              end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
                st = rgcq_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                wr_ptr_nxt = ptr_inc(wr_ptr_r);
                fill_nxt   = fill_r + 1'b1;
              end
            end
            rgcq_pkg::CMD_POLL: begin
              if (in_drain_budget != '0 && readers_r == '0 && fill_r != '0) begin
                limit_nxt = (in_drain_budget > rgcq_pkg::BUDGET_W'(QUEUE_DEPTH)) ?
                            rgcq_pkg::CNT_W'(QUEUE_DEPTH) :
                            in_drain_budget[rgcq_pkg::CNT_W-1:0];
                state_nxt = S_RD;
                sum_go    = 1'b0;
              end
            end
            rgcq_pkg::CMD_SYNC: begin
              if (readers_r != '0) begin
                st = rgcq_pkg::ST_BUSY;
              end else if (fill_r != '0) begin
                limit_nxt = rgcq_pkg::CNT_W'(QUEUE_DEPTH);
                state_nxt = S_RD;
                sum_go    = 1'b0;
              end
            end
            default: begin
            end
          endcase
          if (sum_go) begin
            out_valid_nxt  = 1'b1;
            out_entry_nxt  = 1'b0;
            out_handle_nxt = '0;
            out_arg_nxt    = '0;
            out_status_nxt = st;
            out_cnt_nxt    = '0;
            out_held_nxt   = (readers_nxt != '0);
            out_last_nxt   = 1'b1;
          end
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = 1'b1;
          out_handle_nxt = mem_rdata[rgcq_pkg::ENTRY_W-1:rgcq_pkg::ARG_W];
          out_arg_nxt    = mem_rdata[rgcq_pkg::ARG_W-1:0];
          out_status_nxt = rgcq_pkg::ST_OK;
          out_cnt_nxt    = '0;
          out_held_nxt   = (readers_r != '0);
          out_last_nxt   = 1'b0;
          rd_ptr_nxt     = ptr_inc(rd_ptr_r);
          fill_nxt       = fill_r - 1'b1;
          cnt_nxt        = rgcq_pkg::CNT_W'(cnt_r + 1'b1);
          if ((rgcq_pkg::CNT_W'(cnt_r + 1'b1) == limit_r) || (fill_r == FILL_W'(1))) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = 1'b0;
          out_handle_nxt = '0;
          out_arg_nxt    = '0;
          out_status_nxt = rgcq_pkg::ST_OK;
          out_cnt_nxt    = cnt_r;
          out_held_nxt   = (readers_r != '0);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign mem_waddr = wr_ptr_r;
  assign mem_wdata = {in_handler_handle, in_handler_argument};
  assign mem_raddr = rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      readers_r   <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      limit_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      readers_r   <= readers_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      limit_r     <= limit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_entry_r  <= out_entry_nxt;
    out_handle_r <= out_handle_nxt;
    out_arg_r    <= out_arg_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_held_r   <= out_held_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_entry_valid   = out_entry_r;
  assign out_handle        = out_handle_r;
  assign out_argument      = out_arg_r;
  assign out_status        = out_status_r;
  assign out_drained_count = out_cnt_r;
  assign out_readers_held  = out_held_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

/* design/reader_gated_callback_queue.sv */
// top level of the reader gated callback queue: sequencer plus entry ram
//
//  channel | ports                                          | beat
//  --------+------------------------------------------------+-------------------------------
//  in      | in_valid/in_ready, in_cmd, in_handler_*, budget | one command
//  out     | out_valid/out_ready, out_* result fields        | drained entry or summary
//
// reader and enqueue commands give one summary beat
// a drain reads each entry from the ram, then captures it into the result
// register, and ends with the summary beat
// a new command is taken once the drain loop is done and the result register
// is free or being emptied in that cycle
// out_ready low holds the result register and stops the drain loop
// synchronous reset clears reader count, pointers and fill level; ram is not cleared
`default_nettype none

module reader_gated_callback_queue #(
  parameter int QUEUE_DEPTH       = rgcq_pkg::QUEUE_DEPTH_DEF,
  parameter int READER_COUNT_BITS = rgcq_pkg::READER_COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rgcq_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [rgcq_pkg::HANDLE_W-1:0] in_handler_handle,
  input  wire logic [rgcq_pkg::ARG_W-1:0]    in_handler_argument,
  input  wire logic [rgcq_pkg::BUDGET_W-1:0] in_drain_budget,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_entry_valid,
  output logic      [rgcq_pkg::HANDLE_W-1:0] out_handle,
  output logic      [rgcq_pkg::ARG_W-1:0]    out_argument,
  output logic      [rgcq_pkg::STATUS_W-1:0] out_status,
  output logic      [rgcq_pkg::CNT_W-1:0]    out_drained_count,
  output logic                               out_readers_held,
  output logic                               out_last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic                          mem_we;
  logic [PTR_W-1:0]              mem_waddr;
  logic [rgcq_pkg::ENTRY_W-1:0]  mem_wdata;
  logic                          mem_re;
  logic [PTR_W-1:0]              mem_raddr;
  logic [rgcq_pkg::ENTRY_W-1:0]  mem_rdata;

  rgcq_ctrl #(
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .READER_COUNT_BITS (READER_COUNT_BITS)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_handler_handle   (in_handler_handle),
    .in_handler_argument (in_handler_argument),
    .in_drain_budget     (in_drain_budget),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_valid     (out_entry_valid),
    .out_handle          (out_handle),
    .out_argument        (out_argument),
    .out_status          (out_status),
    .out_drained_count   (out_drained_count),
    .out_readers_held    (out_readers_held),
    .out_last            (out_last),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata)
  );

  rgcq_ram #(
    .WIDTH (rgcq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the reader gated callback queue
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgcq_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [READER_COUNT_BITS_DEF-1:0] READERS_MAX = '1;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
  localparam int RANDOM_ITEMS = 410;
  localparam int READER_REPS = 4;
  localparam int LONG_HOLD = 300;
  localparam longint TIMEOUT_CYCLES = 5_000_000;

  typedef struct packed {
    logic                entry_valid;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    drained_count;
    logic                readers_held;
    logic                last;
  } beat_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
    logic [BUDGET_W-1:0] budget;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    drained_count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd;
  logic [HANDLE_W-1:0] in_handler_handle;
  logic [ARG_W-1:0] in_handler_argument;
  logic [BUDGET_W-1:0] in_drain_budget;
  logic out_valid;
  logic out_ready;
  logic out_entry_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [ARG_W-1:0] out_argument;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0] out_drained_count;
  logic out_readers_held;
  logic out_last;

  reader_gated_callback_queue i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_handler_handle   (in_handler_handle),
    .in_handler_argument (in_handler_argument),
    .in_drain_budget     (in_drain_budget),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_valid     (out_entry_valid),
    .out_handle          (out_handle),
    .out_argument        (out_argument),
    .out_status          (out_status),
    .out_drained_count   (out_drained_count),
    .out_readers_held    (out_readers_held),
    .out_last            (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // queue model state
  logic [READER_COUNT_BITS_DEF-1:0] readers_now;
  logic [HANDLE_W-1:0] ring_handle [DEPTH];
  logic [ARG_W-1:0] ring_arg [DEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_fill;

  beat_t due_beats [$];
  int error_count = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic beat_t make_beat(logic ev, logic [HANDLE_W-1:0] h, logic [ARG_W-1:0] a,
                                      logic [STATUS_W-1:0] st, logic [CNT_W-1:0] cnt,
                                      logic lst);
    beat_t b;
    b.entry_valid = ev;
    b.handle = h;
    b.argument = a;
    b.status = st;
    b.drained_count = cnt;
    b.readers_held = (readers_now != '0);
    b.last = lst;
    return b;
  endfunction

  function automatic void drain_ring(int unsigned limit, ref beat_t res[$]);
    while (res.size() < limit && ring_fill != 0) begin
      res.push_back(make_beat(1'b1, ring_handle[ring_head], ring_arg[ring_head], ST_OK, '0,
                              1'b0));
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
    end
  endfunction

  function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                                        logic [ARG_W-1:0] a, logic [BUDGET_W-1:0] budget,
                                        ref beat_t res[$]);
    logic [STATUS_W-1:0] st;
    int unsigned limit;
    st = ST_OK;
    res.delete();
    case (cmd)
      CMD_READ_ENTER: begin
        if (readers_now != READERS_MAX) readers_now++;
      end
      CMD_READ_EXIT: begin
        if (readers_now != '0) readers_now--;
      end
      CMD_ENQUEUE: begin
        if (h == '0) begin
          st = ST_INVALID;
        end else if (ring_fill >= DEPTH) begin
          st = ST_FULL;
        end else begin
          ring_handle[ring_tail] = h;
          ring_arg[ring_tail] = a;
          ring_tail = (ring_tail + 1) % DEPTH;
          ring_fill++;
        end
      end
      CMD_POLL: begin
        limit = (budget > DEPTH) ? DEPTH : budget;
        if (limit != 0 && readers_now == '0) drain_ring(limit, res);
      end
      CMD_SYNC: begin
        if (readers_now != '0) st = ST_BUSY;
        else drain_ring(DEPTH, res);
      end
      default: ;
    endcase
    res.push_back(make_beat(1'b0, '0, '0, st, CNT_W'(res.size()), 1'b1));
  endfunction

  // one command beat: predict, then hold it on the bus until taken
  task automatic offer_command(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] h,
                               logic [ARG_W-1:0] a, logic [BUDGET_W-1:0] budget,
                               bit typed, logic [STATUS_W-1:0] st, logic [CNT_W-1:0] cnt);
    beat_t res [$];
    int gap;
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    apply_command(cmd, h, a, budget, res);
    if (typed) begin
      res[res.size()-1].status = st;
      res[res.size()-1].drained_count = cnt;
    end
    foreach (res[i]) due_beats.push_back(res[i]);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_handler_handle <= h;
    in_handler_argument <= a;
    in_drain_budget <= budget;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_command();
    logic [CMD_W-1:0] cmd;
    logic [HANDLE_W-1:0] h;
    logic [ARG_W-1:0] a;
    logic [BUDGET_W-1:0] budget;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = CMD_ENQUEUE;
    else if (pick < 55) cmd = CMD_POLL;
    else if (pick < 65) cmd = CMD_SYNC;
    else if (pick < 78) cmd = CMD_READ_ENTER;
    else if (pick < 95) cmd = CMD_READ_EXIT;
    else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    h = {$urandom, $urandom};
    a = {$urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick == 0) h = '0;
    else if (pick == 1) h = '1;
    pick = $urandom_range(0, 9);
    if (pick < 6) budget = BUDGET_W'($urandom_range(0, DEPTH + 4));
    else if (pick < 9) budget = BUDGET_W'($urandom_range(0, 255));
    else budget = '1;
    offer_command(cmd, h, a, budget, 1'b0, ST_OK, '0);
  endtask

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    beat_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing expected: handle %0h status %0d",
               out_handle, out_status);
        error_count++;
      end else begin
        exp = due_beats.pop_front();
        check_field("entry_valid", 64'(exp.entry_valid), 64'(out_entry_valid));
        check_field("handle", exp.handle, out_handle);
        check_field("argument", exp.argument, out_argument);
        check_field("status", 64'(exp.status), 64'(out_status));
        check_field("drained_count", 64'(exp.drained_count), 64'(out_drained_count));
        check_field("readers_held", 64'(exp.readers_held), 64'(out_readers_held));
        check_field("last", 64'(exp.last), 64'(out_last));
      end
    end
  end

  // result receiver with random stalls and one long hold
  initial begin
    int run_len;
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        run_len = $urandom_range(1, 12);
        repeat (run_len) @(posedge clk);
        stall = idle_length();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t rows [25];
    int waited;
    rows = '{
      '{CMD_POLL,       '0, '0, 8'd8,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_SYNC,       '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_READ_EXIT,  '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_ENQUEUE,    '0, '1, 8'd0,   1, 1'b1, ST_INVALID, 6'd0},
      '{CMD_ENQUEUE,    '1, '1, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_ENQUEUE,    64'd1, '0, 8'd0, 1, 1'b1, ST_OK,     6'd0},
      '{CMD_READ_ENTER, '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_POLL,       '0, '0, 8'd255, 1, 1'b1, ST_OK,      6'd0},
      '{CMD_SYNC,       '0, '0, 8'd0,   1, 1'b1, ST_BUSY,    6'd0},
      '{CMD_READ_EXIT,  '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_POLL,       '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_POLL,       '0, '0, 8'd1,   1, 1'b0, ST_OK,      6'd0},
      '{CMD_SYNC,       '0, '0, 8'd0,   1, 1'b0, ST_OK,      6'd0},
      '{CMD_ENQUEUE,    64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, 8'd0,
        DEPTH, 1'b0, ST_OK, 6'd0},
      '{CMD_ENQUEUE,    64'hAAAA_AAAA_AAAA_AAAA, '0, 8'd0, 1, 1'b1, ST_FULL, 6'd0},
      '{CMD_ENQUEUE,    '0, '0, 8'd0,   1, 1'b1, ST_INVALID, 6'd0},
      '{CMD_POLL,       '0, '0, 8'd255, 1, 1'b1, ST_OK,      CNT_W'(DEPTH)},
      '{CMD_POLL,       '0, '0, 8'd33,  1, 1'b1, ST_OK,      6'd0},
      '{CMD_SPARE_FIRST, '1, '1, 8'd255, 1, 1'b1, ST_OK,     6'd0},
      '{CMD_SPARE_FIRST + 3'd1, '1, '0, 8'd7, 1, 1'b1, ST_OK, 6'd0},
      '{CMD_SPARE_LAST, '0, '1, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_READ_ENTER, '0, '0, 8'd0,   READER_REPS, 1'b0, ST_OK, 6'd0},
      '{CMD_READ_ENTER, '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0},
      '{CMD_READ_EXIT,  '0, '0, 8'd0,   READER_REPS, 1'b0, ST_OK, 6'd0},
      '{CMD_READ_EXIT,  '0, '0, 8'd0,   1, 1'b1, ST_OK,      6'd0}
    };
    readers_now = '0;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_READ_ENTER;
    in_handler_handle <= '0;
    in_handler_argument <= '0;
    in_drain_budget <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      no_idle = (rows[r].reps > 1);
      for (int k = 0; k < rows[r].reps; k++) begin
        offer_command(rows[r].cmd, rows[r].handle + HANDLE_W'(k),
                      rows[r].argument ^ ARG_W'(k), rows[r].budget,
                      rows[r].typed, rows[r].status, rows[r].drained_count);
      end
    end

    // fill up behind a long receiver hold, then mixed traffic
    no_idle = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 40) no_idle = 1'b0;
      else if (k % 100 == 70) no_idle = 1'b1;
      else if (k % 100 == 95) no_idle = 1'b0;
      random_command();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    waited = 0;
    while (due_beats.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * DEPTH + 40) @(posedge clk);
    if (due_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", due_beats.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
